[design/cbspl_pkg.sv]
`default_nettype none

package cbspl_pkg;

    // request command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // control that travels down the pipeline with each item
    typedef struct packed {
        logic v;    // stage holds an evaluate request
        logic oor;  // segment out of range
    } ctl_t;

endpackage

`default_nettype wire

[design/cbspl_ram.sv]
`default_nettype none

module cbspl_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    clk,
    input  wire logic                    we,
    input  wire logic [AW-1:0]           waddr,
    input  wire logic [WIDTH-1:0]        wdata,
    input  wire logic                    re,
    input  wire logic [AW-1:0]           raddr,
    output logic      [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/cbspl_wgt.sv]
`default_nettype none

// basis weights from t: five register stages
module cbspl_wgt #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire cbspl_pkg::ctl_t               ctl_in,
    input  wire logic [FRAC_BITS:0]            t_in,
    output cbspl_pkg::ctl_t                    ctl_out,
    output logic      [3:0][FRAC_BITS+3:0]     w_out,
    output logic      [3:0][FRAC_BITS+3:0]     d_out
);

    localparam int TW  = FRAC_BITS + 1;
    localparam int WW  = FRAC_BITS + 4;
    localparam int PW2 = 2 * TW;
    localparam int K   = FRAC_BITS + 5;
    localparam int MW  = WW + K;
    localparam logic [PW2-1:0] HALF = PW2'(1) << (FRAC_BITS - 1);
    localparam logic [K-1:0] RECIP = K'((64'd1 << K) / 64'd6);
    localparam logic signed [WW-1:0] ONE_W = WW'(1) << FRAC_BITS;

    cbspl_pkg::ctl_t ctl_reg [5];

    logic [TW-1:0] s2_t_reg, s2_t2_reg;
    logic [TW-1:0] s3_t_reg, s3_t2_reg, s3_t3_reg;
    logic [3:0][WW-1:0] s3_d_reg, s4_d_reg, s5_d_reg, s6_d_reg;
    logic [3:0][WW-1:0] s4_m_reg, s5_m_reg, s5_q_reg, s6_w_reg;
    logic [3:0] s4_sg_reg, s5_sg_reg;

    logic [TW-1:0] s2_t2_next, s3_t3_next;
    logic [PW2-1:0] sq, cu;
    logic [3:0][WW-1:0] s3_d_next, s4_m_next, s5_q_next, s6_w_next;
    logic [3:0] s4_sg_next;
    logic signed [WW-1:0] ts2, t2s2, ts3, t2s3, t3s3;
    logic signed [WW-1:0] num [4];
    logic signed [WW-1:0] mag;
    logic [MW-1:0] prod;
    logic [WW+2:0] six_q, rem;
    logic [WW-1:0] q;

    // squares and cubes of t, rounded back to the fraction width
    always_comb
    begin
        sq = PW2'(t_in) * PW2'(t_in);
        s2_t2_next = TW'((sq + HALF) >> FRAC_BITS);
        cu = PW2'(s2_t2_reg) * PW2'(s2_t_reg);
        s3_t3_next = TW'((cu + HALF) >> FRAC_BITS);
    end

    // tangent weights, twice the true value
    always_comb
    begin
        ts2  = $signed(WW'(s2_t_reg));
        t2s2 = $signed(WW'(s2_t2_reg));
        s3_d_next[0] = (ts2 <<< 1) - t2s2 - ONE_W;
        s3_d_next[1] = (t2s2 <<< 1) + t2s2 - (ts2 <<< 2);
        s3_d_next[2] = ONE_W + (ts2 <<< 1) - (t2s2 <<< 1) - t2s2;
        s3_d_next[3] = t2s2;
    end

    // position numerators, split into magnitude plus rounding bias and sign
    always_comb
    begin
        ts3  = $signed(WW'(s3_t_reg));
        t2s3 = $signed(WW'(s3_t2_reg));
        t3s3 = $signed(WW'(s3_t3_reg));
        num[0] = ONE_W - (ts3 <<< 1) - ts3 + (t2s3 <<< 1) + t2s3 - t3s3;
        num[1] = (t3s3 <<< 1) + t3s3 - (t2s3 <<< 2) - (t2s3 <<< 1) + (ONE_W <<< 2);
        num[2] = ONE_W + (ts3 <<< 1) + ts3 + (t2s3 <<< 1) + t2s3 - (t3s3 <<< 1) - t3s3;
        num[3] = t3s3;
        for (int k = 0; k < 4; k++)
        begin
            s4_sg_next[k] = num[k][WW-1];
            mag = s4_sg_next[k] ? -num[k] : num[k];
            s4_m_next[k] = WW'(mag) + WW'(3);
        end
    end

    // divide by six: reciprocal multiply, then one correction step
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            prod = MW'(s4_m_reg[k]) * MW'(RECIP);
            s5_q_next[k] = WW'(prod >> K);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            six_q = ((WW+3)'(s5_q_reg[k]) << 2) + ((WW+3)'(s5_q_reg[k]) << 1);
            rem = (WW+3)'(s5_m_reg[k]) - six_q;
            q = (rem >= (WW+3)'(6)) ? s5_q_reg[k] + WW'(1) : s5_q_reg[k];
            s6_w_next[k] = s5_sg_reg[k] ? -q : q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            for (int i = 1; i < 5; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_t_reg  <= t_in;
            s2_t2_reg <= s2_t2_next;
            s3_t_reg  <= s2_t_reg;
            s3_t2_reg <= s2_t2_reg;
            s3_t3_reg <= s3_t3_next;
            s3_d_reg  <= s3_d_next;
            s4_d_reg  <= s3_d_reg;
            s4_m_reg  <= s4_m_next;
            s4_sg_reg <= s4_sg_next;
            s5_d_reg  <= s4_d_reg;
            s5_m_reg  <= s4_m_reg;
            s5_sg_reg <= s4_sg_reg;
            s5_q_reg  <= s5_q_next;
            s6_d_reg  <= s5_d_reg;
            s6_w_reg  <= s6_w_next;
        end
    end

    assign ctl_out = ctl_reg[4];
    assign w_out   = s6_w_reg;
    assign d_out   = s6_d_reg;

endmodule

`default_nettype wire

[design/cbspl_mac.sv]
`default_nettype none

// weighted sums of the four points: products, sums, round and saturate
module cbspl_mac #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   en,
    input  wire cbspl_pkg::ctl_t                        ctl_in,
    input  wire logic [3:0][FRAC_BITS+3:0]              w_in,
    input  wire logic [3:0][FRAC_BITS+3:0]              d_in,
    input  wire logic [3:0][2:0][COORD_WIDTH-1:0]       pts_in,
    output logic                                        res_valid,
    output logic      [6*COORD_WIDTH:0]                 res_data
);

    localparam int CW = COORD_WIDTH;
    localparam int WW = FRAC_BITS + 4;
    localparam int PW = CW + WW;
    localparam int AW = PW + 2;

    cbspl_pkg::ctl_t ctl_reg [3];

    logic signed [PW-1:0] pp_reg [3][4];
    logic signed [PW-1:0] tp_reg [3][4];
    logic signed [AW-1:0] ps_reg [3];
    logic signed [AW-1:0] ts_reg [3];
    logic [CW-1:0] pos_reg [3];
    logic [CW-1:0] tan_reg [3];

    logic signed [PW-1:0] pp_next [3][4];
    logic signed [PW-1:0] tp_next [3][4];
    logic signed [AW-1:0] ps_next [3];
    logic signed [AW-1:0] ts_next [3];
    logic [CW-1:0] pos_next [3];
    logic [CW-1:0] tan_next [3];
    logic signed [AW-1:0] rp, rt;

    function automatic logic [CW-1:0] sat(input logic signed [AW-1:0] v);
        logic fits;
        fits = (v[AW-1:CW-1] == {(AW-CW+1){v[AW-1]}});
        if (fits)
            return v[CW-1:0];
        else if (v[AW-1])
            return {1'b1, {(CW-1){1'b0}}};
        else
            return {1'b0, {(CW-1){1'b1}}};
    endfunction

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                pp_next[c][k] = PW'($signed(pts_in[k][c])) * PW'($signed(w_in[k]));
                tp_next[c][k] = PW'($signed(pts_in[k][c])) * PW'($signed(d_in[k]));
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ps_next[c] = '0;
            ts_next[c] = '0;
            for (int k = 0; k < 4; k++)
            begin
                ps_next[c] = ps_next[c] + AW'(pp_reg[c][k]);
                ts_next[c] = ts_next[c] + AW'(tp_reg[c][k]);
            end
        end
    end

    // round half up, floor shift; out-of-range segments give zero
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            rp = (ps_reg[c] + (AW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            rt = (ts_reg[c] + (AW'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
            pos_next[c] = ctl_reg[1].oor ? '0 : sat(rp);
            tan_next[c] = ctl_reg[1].oor ? '0 : sat(rt);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            ctl_reg[1] <= ctl_reg[0];
            ctl_reg[2] <= ctl_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg  <= pp_next;
            tp_reg  <= tp_next;
            ps_reg  <= ps_next;
            ts_reg  <= ts_next;
            pos_reg <= pos_next;
            tan_reg <= tan_next;
        end
    end

    assign res_valid = ctl_reg[2].v;
    assign res_data  = {ctl_reg[2].oor, tan_reg[2], tan_reg[1], tan_reg[0],
                        pos_reg[2], pos_reg[1], pos_reg[0]};

endmodule

`default_nettype wire

[design/cubic_bspline_point_and_tangent.sv]
`default_nettype none

// uniform cubic b-spline evaluator, position and tangent per request
// request channel: req_valid / req_stall; a request is taken at a clock edge
//   with req_valid high and req_stall low. command write stores one control
//   point at point_index and gives no result; command evaluate reads points
//   segment_index-1 .. segment_index+2 and gives one result
// result channel: rsp_valid / rsp_stall; pos_*, tan_*, status hold while stalled
// throughput: one request per cycle if unstalled; writes, evaluates mix freely
// a result passes the point store read, the weight pipeline (square,
//   cube, numerators, reciprocal multiply, divide correction), the
//   multiply-accumulate stages and then the output register
// a point written by one request is seen by an evaluate in the very next cycle
// reset clears all valid bits and sets point_count to 4; the point store keeps
//   no reset value and must be written before it is read
// stall: results park in an output register plus a skid register; req_stall is
//   registered and rises at the edge that catches a result in the skid, then
//   the whole pipeline holds until the skid drains. cfg_write loads
//   point_count; user must do so only while no request is in flight, unenforced
module cubic_bspline_point_and_tangent #(
    parameter int MAX_POINTS  = 256,
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request channel
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic                          command,
    input  wire logic        [7:0]             point_index,
    input  wire logic signed [COORD_WIDTH-1:0] coord_x,
    input  wire logic signed [COORD_WIDTH-1:0] coord_y,
    input  wire logic signed [COORD_WIDTH-1:0] coord_z,
    input  wire logic        [7:0]             segment_index,
    input  wire logic        [16:0]            t_param,
    // result channel
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic signed      [COORD_WIDTH-1:0] pos_x,
    output logic signed      [COORD_WIDTH-1:0] pos_y,
    output logic signed      [COORD_WIDTH-1:0] pos_z,
    output logic signed      [COORD_WIDTH-1:0] tan_x,
    output logic signed      [COORD_WIDTH-1:0] tan_y,
    output logic signed      [COORD_WIDTH-1:0] tan_z,
    output logic                               status,
    // configuration
    input  wire logic                          cfg_write,
    input  wire logic        [8:0]             cfg_data
);

    localparam int CW   = COORD_WIDTH;
    localparam int TW   = FRAC_BITS + 1;
    localparam int WW   = FRAC_BITS + 4;
    localparam int RW   = 6 * CW + 1;
    localparam int SW   = $clog2(MAX_POINTS);
    localparam int BD   = (MAX_POINTS + 3) / 4;
    localparam int BAW  = (BD > 1) ? $clog2(BD) : 1;
    localparam int CNTW = ($clog2(MAX_POINTS + 1) > 10) ? $clog2(MAX_POINTS + 1) : 10;
    localparam int CMPW = (TW > 17) ? TW : 17;
    localparam int DLY  = 5;

    // pipeline moves whenever the skid register is empty
    logic adv, accept, wr_en;
    logic [8:0] point_count_reg;

    // four banks, interleaved on the low two index bits, so the four
    // consecutive points of a segment come from four different banks
    logic [SW-1:0] slot;
    logic [9:0] base, idx;
    logic [1:0] off;
    logic [3:0][BAW-1:0] raddr;
    wire logic [3:0][3*CW-1:0] rdata;

    logic [CNTW-1:0] cnt_eff, pc_ext, max_c;
    logic oor;
    logic [CMPW-1:0] t_ext, one_ext;
    logic [TW-1:0] t_clamp;

    cbspl_pkg::ctl_t s1_ctl_reg, s1_ctl_next;
    logic [TW-1:0] s1_t_reg;
    logic [1:0] s1_base_reg;

    logic [3:0][2:0][CW-1:0] pts_s1;
    logic [DLY-1:0][3:0][2:0][CW-1:0] pts_dly_reg;

    cbspl_pkg::ctl_t wgt_ctl;
    logic [3:0][WW-1:0] wgt_w, wgt_d;

    logic mac_v;
    logic [RW-1:0] mac_d;

    // output register plus skid register
    logic out_v_reg, out_v_next, skid_v_reg, skid_v_next, out_fire;
    logic [RW-1:0] out_d_reg, out_d_next, skid_d_reg, skid_d_next;

    assign adv       = !skid_v_reg;
    assign req_stall = skid_v_reg;
    assign accept    = req_valid && !req_stall;
    assign wr_en     = accept && (command == cbspl_pkg::CMD_WRITE);

    // write slot is point_index modulo the store depth
    always_comb
    begin : slot_map
        int unsigned r;
        slot = '0;
        r = 0;
        for (int i = 0; i < (1 << $bits(point_index)); i++)
        begin
            if (point_index == 8'(i))
            begin
                slot = SW'(r);
            end
            r = (r == MAX_POINTS - 1) ? 0 : r + 1;
        end
    end

    // bank b holds the segment point whose index is b modulo four
    always_comb
    begin
        base = {2'b00, segment_index} - 10'd1;
        for (int b = 0; b < 4; b++)
        begin
            off = 2'(b) - base[1:0];
            idx = base + {8'b0, off};
            raddr[b] = BAW'(idx >> 2);
        end
    end

    generate
        for (genvar b = 0; b < 4; b++)
        begin : g_bank
            cbspl_ram #(
                .WIDTH (3 * CW),
                .DEPTH (BD)
            ) u_bank (
                .clk   (clk),
                .we    (wr_en && (slot[1:0] == 2'(b))),
                .waddr (BAW'(slot >> 2)),
                .wdata ({coord_z, coord_y, coord_x}),
                .re    (adv),
                .raddr (raddr[b]),
                .rdata (rdata[b])
            );
        end
    endgenerate

    // segment range check against the loaded point count
    always_comb
    begin
        pc_ext  = CNTW'(point_count_reg);
        max_c   = CNTW'(MAX_POINTS);
        cnt_eff = (pc_ext > max_c) ? max_c : pc_ext;
        oor     = (segment_index == 8'd0) ||
                  ((CNTW'(segment_index) + CNTW'(2)) >= cnt_eff);
    end

    // t above one is held at one
    always_comb
    begin
        t_ext   = CMPW'(t_param);
        one_ext = CMPW'(1) << FRAC_BITS;
        t_clamp = (t_ext > one_ext) ? TW'(one_ext) : TW'(t_ext);
    end

    always_comb
    begin
        s1_ctl_next.v   = accept && (command == cbspl_pkg::CMD_EVAL);
        s1_ctl_next.oor = oor;
    end

    // undo the bank interleave: point k sits in bank (i - 1 + k) mod 4
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                pts_s1[k][c] = rdata[2'(s1_base_reg + 2'(k))][c*CW +: CW];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= 9'd4;
            s1_ctl_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                point_count_reg <= cfg_data;
            end
            if (adv)
            begin
                s1_ctl_reg <= s1_ctl_next;
            end
        end
    end

    // points wait alongside the weight pipeline
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_t_reg       <= t_clamp;
            s1_base_reg    <= base[1:0];
            pts_dly_reg[0] <= pts_s1;
            for (int i = 1; i < DLY; i++)
            begin
                pts_dly_reg[i] <= pts_dly_reg[i-1];
            end
        end
    end

    cbspl_wgt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_wgt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .ctl_in  (s1_ctl_reg),
        .t_in    (s1_t_reg),
        .ctl_out (wgt_ctl),
        .w_out   (wgt_w),
        .d_out   (wgt_d)
    );

    cbspl_mac #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .ctl_in    (wgt_ctl),
        .w_in      (wgt_w),
        .d_in      (wgt_d),
        .pts_in    (pts_dly_reg[DLY-1]),
        .res_valid (mac_v),
        .res_data  (mac_d)
    );

    // output and skid: a result that meets a stalled full output register
    // goes to the skid, which then holds the pipeline until it drains
    always_comb
    begin
        out_v_next  = out_v_reg;
        out_d_next  = out_d_reg;
        skid_v_next = skid_v_reg;
        skid_d_next = skid_d_reg;
        out_fire    = out_v_reg && !rsp_stall;
        if (skid_v_reg)
        begin
            if (out_fire)
            begin
                out_d_next  = skid_d_reg;
                skid_v_next = 1'b0;
            end
        end
        else if (mac_v)
        begin
            if (!out_v_reg || out_fire)
            begin
                out_v_next = 1'b1;
                out_d_next = mac_d;
            end
            else
            begin
                skid_v_next = 1'b1;
                skid_d_next = mac_d;
            end
        end
        else if (out_fire)
        begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_d_reg  <= out_d_next;
        skid_d_reg <= skid_d_next;
    end

    assign rsp_valid = out_v_reg;
    assign pos_x  = out_d_reg[0*CW +: CW];
    assign pos_y  = out_d_reg[1*CW +: CW];
    assign pos_z  = out_d_reg[2*CW +: CW];
    assign tan_x  = out_d_reg[3*CW +: CW];
    assign tan_y  = out_d_reg[4*CW +: CW];
    assign tan_z  = out_d_reg[5*CW +: CW];
    assign status = out_d_reg[RW-1];

endmodule

`default_nettype wire

[bench/cbspl_checker.sv]
`default_nettype none

module cbspl_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    input  wire logic               req_stall,
    input  wire logic               command,
    input  wire logic        [7:0]  point_index,
    input  wire logic signed [31:0] coord_x,
    input  wire logic signed [31:0] coord_y,
    input  wire logic signed [31:0] coord_z,
    input  wire logic        [7:0]  segment_index,
    input  wire logic        [16:0] t_param,
    input  wire logic               rsp_valid,
    input  wire logic               rsp_stall,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic signed [31:0] tan_x,
    input  wire logic signed [31:0] tan_y,
    input  wire logic signed [31:0] tan_z,
    input  wire logic               status,
    input  wire logic               cfg_write,
    input  wire logic        [8:0]  cfg_data,
    output int                      fail_count,
    output int                      pending,
    output int                      eval_count,
    output int                      oor_count
);

    typedef struct {
        logic signed [31:0] v[6];
        logic               st;
    } curve_sample_t;

    localparam longint ONE = 64'sd65536;

    longint        ctrl_pts[256][3];
    logic [8:0]    loaded_count;
    curve_sample_t samples_due[$];

    function automatic longint div6_round(longint n);
        if (n >= 0)
            return (n + 3) / 6;
        return -((-n + 3) / 6);
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic curve_sample_t eval_segment(int seg, longint traw);
        curve_sample_t r;
        longint t, t2, t3, pa, ta;
        longint w[4], d[4];
        int lim;
        lim = (loaded_count > 256) ? 256 : int'(loaded_count);
        r.st = 1'b0;
        for (int k = 0; k < 6; k++)
            r.v[k] = '0;
        if (seg < 1 || seg + 2 >= lim) begin
            r.st = 1'b1;
            return r;
        end
        t  = (traw > ONE) ? ONE : traw;
        t2 = (t * t + ONE / 2) >>> 16;
        t3 = (t2 * t + ONE / 2) >>> 16;
        w[0] = div6_round(ONE - 3 * t + 3 * t2 - t3);
        w[1] = div6_round(3 * t3 - 6 * t2 + 4 * ONE);
        w[2] = div6_round(-3 * t3 + 3 * t2 + 3 * t + ONE);
        w[3] = div6_round(t3);
        d[0] = -(t2 - 2 * t + ONE);
        d[1] = 3 * t2 - 4 * t;
        d[2] = -3 * t2 + 2 * t + ONE;
        d[3] = t2;
        for (int c = 0; c < 3; c++) begin
            pa = 0;
            ta = 0;
            for (int k = 0; k < 4; k++) begin
                pa += ctrl_pts[seg - 1 + k][c] * w[k];
                ta += ctrl_pts[seg - 1 + k][c] * d[k];
            end
            // floor shifts with half added, as arithmetic right shift
            r.v[c]     = clip32((pa + (64'sd1 <<< 15)) >>> 16);
            r.v[3 + c] = clip32((ta + (64'sd1 <<< 16)) >>> 17);
        end
        return r;
    endfunction

    assign pending = samples_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        curve_sample_t exp_s;
        logic signed [31:0] got[6];
        if (!rst_n) begin
            loaded_count = 9'd4;
            samples_due.delete();
            fail_count = 0;
            eval_count = 0;
            oor_count  = 0;
        end else begin
            if (cfg_write)
                loaded_count = cfg_data;
            if (rsp_valid && !rsp_stall) begin
                got = '{pos_x, pos_y, pos_z, tan_x, tan_y, tan_z};
                if (samples_due.size() == 0) begin
                    $display("%0t: result with nothing expected: pos %0d %0d %0d", $time,
                             pos_x, pos_y, pos_z);
                    fail_count++;
                end else begin
                    exp_s = samples_due.pop_front();
                    for (int k = 0; k < 6; k++)
                        if (got[k] !== exp_s.v[k]) begin
                            $display("%0t: field %0d expected %0d actual %0d", $time, k,
                                     exp_s.v[k], got[k]);
                            fail_count++;
                        end
                    if (status !== exp_s.st) begin
                        $display("%0t: status expected %0d actual %0d", $time, exp_s.st,
                                 status);
                        fail_count++;
                    end
                end
            end
            if (req_valid && !req_stall) begin
                if (command == cbspl_pkg::CMD_WRITE) begin
                    ctrl_pts[point_index][0] = longint'(coord_x);
                    ctrl_pts[point_index][1] = longint'(coord_y);
                    ctrl_pts[point_index][2] = longint'(coord_z);
                end else begin
                    exp_s = eval_segment(int'(segment_index), longint'(t_param));
                    eval_count++;
                    if (exp_s.st)
                        oor_count++;
                    samples_due.insert(samples_due.size(), exp_s);
                end
            end
        end
    end

endmodule

`default_nettype wire

[bench/tb.sv]
`default_nettype none

module tb;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    logic               command;
    logic        [7:0]  point_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic        [7:0]  segment_index;
    logic        [16:0] t_param;
    logic               rsp_valid;
    logic               rsp_stall;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [31:0] tan_x, tan_y, tan_z;
    logic               status;
    logic               cfg_write;
    logic        [8:0]  cfg_data;

    int fail_count, pending, eval_count, oor_count;

    // idle rates in percent, long receiver hold request
    int send_idle_pct;
    int rcv_idle_pct;
    bit long_hold_kick;
    int hold_left;

    cubic_bspline_point_and_tangent DUT (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .command(command), .point_index(point_index),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .segment_index(segment_index), .t_param(t_param),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .tan_x(tan_x), .tan_y(tan_y), .tan_z(tan_z),
        .status(status),
        .cfg_write(cfg_write), .cfg_data(cfg_data)
    );

    cbspl_checker spline_check (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .command(command), .point_index(point_index),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .segment_index(segment_index), .t_param(t_param),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .tan_x(tan_x), .tan_y(tan_y), .tan_z(tan_z),
        .status(status),
        .cfg_write(cfg_write), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending),
        .eval_count(eval_count), .oor_count(oor_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

    // result side: random stalls, or a long hold when asked for
    initial
    begin
        rsp_stall = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (long_hold_kick) begin
                long_hold_kick = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_stall <= 1'b1;
            end else begin
                rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
            end
        end
    end

    // random coordinate, leaning on the extremes now and then
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return $signed($urandom_range(65535, 0)) - 32'sd32768;
            default: return $urandom;
        endcase
    endfunction

    // t spread over the interesting points: ends, mid, above one
    function automatic logic [16:0] rand_t();
        case ($urandom_range(9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'h1ffff;
            3: return 17'(65537 + $urandom_range(65534));
            default: return 17'($urandom_range(65535));
        endcase
    endfunction

    // one request on the channel; valid stays high into the next request
    task automatic put_request(logic cmd, logic [7:0] idx, logic signed [31:0] x,
                               logic signed [31:0] y, logic signed [31:0] z,
                               logic [7:0] seg, logic [16:0] t);
        if ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        req_valid     <= 1'b1;
        command       <= cmd;
        point_index   <= idx;
        coord_x       <= x;
        coord_y       <= y;
        coord_z       <= z;
        segment_index <= seg;
        t_param       <= t;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic write_point(logic [7:0] idx, logic signed [31:0] x,
                               logic signed [31:0] y, logic signed [31:0] z);
        put_request(cbspl_pkg::CMD_WRITE, idx, x, y, z, 8'($urandom), 17'($urandom));
    endtask

    task automatic eval_at(logic [7:0] seg, logic [16:0] t);
        put_request(cbspl_pkg::CMD_EVAL, 8'($urandom), $urandom, $urandom, $urandom,
                    seg, t);
    endtask

    // drop valid, let every result come home, then let the pipe settle
    task automatic drain_all();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic load_count(logic [8:0] v);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        logic [8:0] counts[6];
        int mode;
        counts = '{9'd256, 9'd8, 9'd4, 9'd511, 9'd300, 9'd5};
        rst_n = 1'b0;
        req_valid = 1'b0;
        command = cbspl_pkg::CMD_WRITE;
        point_index = '0;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        segment_index = '0;
        t_param = '0;
        cfg_write = 1'b0;
        cfg_data = '0;
        long_hold_kick = 1'b0;
        send_idle_pct = 0;
        rcv_idle_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole store first so no evaluate ever touches an unwritten slot;
        // the first slots alternate full-scale values to force saturation
        for (int i = 0; i < 256; i++) begin
            if (i < 4)
                write_point(8'(i), (i % 2) ? 32'sh80000000 : 32'sh7fffffff,
                            (i % 2) ? 32'sh7fffffff : 32'sh80000000,
                            (i < 2) ? 32'sh7fffffff : 32'sh80000000);
            else
                write_point(8'(i), rand_coord(), rand_coord(), rand_coord());
        end

        // directed, reset point count of 4: only segment 1 is in range
        eval_at(8'd0, 17'd0);
        eval_at(8'd1, 17'd0);
        eval_at(8'd1, 17'd65536);
        eval_at(8'd1, 17'd32768);
        eval_at(8'd1, 17'h1ffff);
        eval_at(8'd2, 17'd100);
        eval_at(8'd255, 17'd65536);
        // write then evaluate back to back, the new point must be seen at once
        write_point(8'd2, 32'sd65536, -32'sd65536, 32'sd0);
        eval_at(8'd1, 17'd16384);
        write_point(8'd3, 32'sd0, 32'sd0, 32'sd0);
        eval_at(8'd1, 17'd49152);
        drain_all();
        load_count(9'd256);
        eval_at(8'd253, 17'd65535);
        eval_at(8'd254, 17'd1);
        eval_at(8'd252, 17'd1);
        drain_all();

        // random phases, each under a different point count and one of three idle patterns
        for (int ph = 0; ph < 6; ph++) begin
            load_count(counts[ph]);
            mode = ph % 3;
            send_idle_pct = (mode == 0) ? 10 : (mode == 1) ? 45 : 0;
            rcv_idle_pct  = (mode == 0) ? 45 : (mode == 1) ? 10 : 0;
            for (int n = 0; n < 140; n++) begin
                if (n == 60 && ph == 2)
                    long_hold_kick = 1'b1;
                if (n == 100 && ph != 5) begin
                    // sender waits out every outstanding result
                    drain_all();
                end
                if ($urandom_range(99) < 20)
                    write_point(8'($urandom), rand_coord(), rand_coord(), rand_coord());
                else if ($urandom_range(3) == 0)
                    eval_at(8'($urandom), rand_t());
                else
                    eval_at(8'($urandom_range(counts[ph] > 256 ? 255 : counts[ph] - 1)),
                            rand_t());
            end
            drain_all();
        end

        repeat (20) @(posedge clk);
        $display("covered: full store load, %0d evaluations (%0d out of range),",
                 eval_count, oor_count);
        $display("six point counts from 4 to 511, saturation, t at and past one");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
